// File: rtl/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sgm_pkg;

   localparam int PIX_W = 8;
   localparam int CFG_W = 12;
   localparam int COL_W = 11;
   localparam int ROW_W = 12;
   localparam int ABS_W = 10;
   localparam int RAD_W = 2 * PIX_W;
   localparam int MIN_DIM = 3;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int FIFO_DEPTH = 4;

   localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = CFG_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } csr_reg_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             frame_end;
   } meta_type;

   typedef struct packed {
      logic [ABS_W-1:0] abs_x;
      logic [ABS_W-1:0] abs_y;
      meta_type         meta;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic almost_full;
   } fifo_stat_type;

endpackage
`default_nettype wire

// File: rtl/sgm_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sgm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/sgm_fifo.sv
// Small register queue between the window front end and the magnitude back end.
`timescale 1ns / 1ps
`default_nettype none
module sgm_fifo #(
   parameter int DEPTH = sgm_pkg::FIFO_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sgm_pkg::item_type     push_item,
   input  wire logic                  pop,
   output sgm_pkg::item_type          head_item,
   output sgm_pkg::fifo_stat_type     stat
);
   import sgm_pkg::*;

   // Pointers wrap naturally, so the user must keep DEPTH a power of two; the block does not enforce it.
   localparam int AW = $clog2(DEPTH);

   item_type      mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW:0]   count_ff;
   logic [AW:0]   count_in;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (AW+1)'(1);
         2'b01:   count_in = count_ff - (AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         count_ff <= count_in;
      end
   end

   assign head_item        = mem_ff[rd_ptr_ff];
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == (AW+1)'(DEPTH));
   assign stat.almost_full = (count_ff >= (AW+1)'(DEPTH - 1));

endmodule
`default_nettype wire

// File: rtl/sgm_front.sv
// Front end: request intake, raster position, line store, 3x3 window and Sobel sums.
`timescale 1ns / 1ps
`default_nettype none
module sgm_front #(
   parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [sgm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sgm_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [sgm_pkg::PIX_W-1:0]        req_pixel,
   input  wire sgm_pkg::fifo_stat_type           q_stat,
   output logic                                  q_push,
   output sgm_pkg::item_type                     q_item
);
   import sgm_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;

   logic [CFG_W-1:0] image_width_ff;
   logic [CFG_W-1:0] image_height_ff;

   logic [XW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [CW-1:0]    w_eff;
   logic [CW-1:0]    w_ext;
   logic [ROW_W-1:0] h_eff;
   logic [XW-1:0]    x;
   logic [ROW_W:0]   y_t;
   logic [ROW_W-1:0] y;
   logic [CW-1:0]    x_next;
   logic [ROW_W:0]   y_next;
   logic             accept;
   logic             interior;
   logic             frame_end;

   logic             s1_vld_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [XW-1:0]    s1_x_ff;
   logic             s1_int_ff;
   meta_type         s1_meta_ff;

   logic [2*PIX_W-1:0] rd_data;
   logic [PIX_W-1:0]   win_ff [6];
   logic [PIX_W-1:0]   top, mid, bot;
   logic [ABS_W-1:0]   pos_x, neg_x, pos_y, neg_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data;
         endcase
      end
   end

   // Position of the incoming pixel, including the clean-up after a geometry change.
   always_comb begin
      w_ext = CW'(image_width_ff);
      if (w_ext < CW'(MIN_DIM)) begin
         w_eff = CW'(MIN_DIM);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      h_eff = (image_height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height_ff;

      if (CW'(col_ff) >= w_eff) begin
         x   = '0;
         y_t = {1'b0, row_ff} + (ROW_W+1)'(1);
      end else begin
         x   = col_ff;
         y_t = {1'b0, row_ff};
      end
      y = (y_t >= {1'b0, h_eff}) ? '0 : y_t[ROW_W-1:0];

      x_next = CW'(x) + CW'(1);
      y_next = {1'b0, y} + (ROW_W+1)'(1);
      if (x_next >= w_eff) begin
         col_in = '0;
         row_in = (y_next >= {1'b0, h_eff}) ? '0 : y_next[ROW_W-1:0];
      end else begin
         col_in = x_next[XW-1:0];
         row_in = y;
      end

      interior  = (x >= XW'(2)) && (y >= ROW_W'(2));
      frame_end = (CW'(x) == w_eff - CW'(1)) && (y == h_eff - ROW_W'(1));
   end

   // The queue must have room for the request still in the window stage.
   assign req_full = q_stat.almost_full;
   assign accept   = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff          <= req_pixel;
         s1_x_ff              <= x;
         s1_int_ff            <= interior;
         s1_meta_ff.column    <= COL_W'(x - XW'(1));
         s1_meta_ff.row       <= y - ROW_W'(1);
         s1_meta_ff.frame_end <= frame_end;
      end
   end

   // Each word holds the two previous rows at one column: row y-2 high, row y-1 low.
   sgm_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_x_ff),
      .wr_data ({mid, bot}),
      .rd_en   (accept),
      .rd_addr (x),
      .rd_data (rd_data)
   );

   assign top = rd_data[2*PIX_W-1:PIX_W];
   assign mid = rd_data[PIX_W-1:0];
   assign bot = s1_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_vld_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   // Positive and negative kernel halves are summed apart, so only magnitudes are kept.
   always_comb begin
      pos_x = ABS_W'(top) + ABS_W'({mid, 1'b0}) + ABS_W'(bot);
      neg_x = ABS_W'(win_ff[0]) + ABS_W'({win_ff[1], 1'b0}) + ABS_W'(win_ff[2]);
      pos_y = ABS_W'(win_ff[2]) + ABS_W'({win_ff[5], 1'b0}) + ABS_W'(bot);
      neg_y = ABS_W'(win_ff[0]) + ABS_W'({win_ff[3], 1'b0}) + ABS_W'(top);
      q_item.abs_x = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
      q_item.abs_y = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
      q_item.meta  = s1_meta_ff;
   end

   assign q_push = s1_vld_ff && s1_int_ff;

endmodule
`default_nettype wire

// File: rtl/sgm_back.sv
// Back end: squares, saturation and a one-bit-per-stage square root pipeline.
`timescale 1ns / 1ps
`default_nettype none
module sgm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sgm_pkg::fifo_stat_type        q_stat,
   input  wire sgm_pkg::item_type             q_item,
   output logic                               q_pop,
   input  wire logic                          rsp_pop,
   output logic                               rsp_empty,
   output logic [sgm_pkg::PIX_W-1:0]          rsp_magnitude,
   output logic [sgm_pkg::COL_W-1:0]          rsp_column,
   output logic [sgm_pkg::ROW_W-1:0]          rsp_row,
   output logic                               rsp_frame_end
);
   import sgm_pkg::*;

   localparam int SQ_W = 2 * ABS_W;
   localparam int NS   = PIX_W;

   logic              en;

   logic              sq_vld_ff;
   logic [SQ_W-1:0]   sq_a_ff, sq_b_ff;
   meta_type          sq_meta_ff;

   logic              sum_vld_ff;
   logic [RAD_W-1:0]  sum_rad_ff;
   meta_type          sum_meta_ff;
   logic [SQ_W:0]     sum_full;

   logic              rt_vld_ff  [NS];
   logic [PIX_W-1:0]  rt_root_ff [NS];
   logic [RAD_W-1:0]  rt_rad_ff  [NS];
   meta_type          rt_meta_ff [NS];
   logic [PIX_W-1:0]  rt_root_in [NS];

   // The whole pipeline moves unless a finished result is waiting and is not popped.
   assign en    = !rt_vld_ff[NS-1] || rsp_pop;
   assign q_pop = en && !q_stat.empty;

   // Clamping to all ones gives a root of 255, which is the saturated result.
   assign sum_full = (SQ_W+1)'(sq_a_ff) + (SQ_W+1)'(sq_b_ff);

   always_comb begin
      logic [PIX_W-1:0] cand;
      cand = PIX_W'(1) << (NS - 1);
      rt_root_in[0] = (RAD_W'(cand) * RAD_W'(cand) <= sum_rad_ff) ? cand : '0;
      for (int k = 1; k < NS; k++) begin
         cand = rt_root_ff[k-1] | (PIX_W'(1) << (NS - 1 - k));
         rt_root_in[k] = (RAD_W'(cand) * RAD_W'(cand) <= rt_rad_ff[k-1]) ?
                         cand : rt_root_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
         for (int k = 0; k < NS; k++) begin
            rt_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         sq_vld_ff    <= q_pop;
         sum_vld_ff   <= sq_vld_ff;
         rt_vld_ff[0] <= sum_vld_ff;
         for (int k = 1; k < NS; k++) begin
            rt_vld_ff[k] <= rt_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_a_ff     <= SQ_W'(q_item.abs_x) * SQ_W'(q_item.abs_x);
         sq_b_ff     <= SQ_W'(q_item.abs_y) * SQ_W'(q_item.abs_y);
         sq_meta_ff  <= q_item.meta;
         sum_rad_ff  <= (sum_full[SQ_W:RAD_W] != '0) ? '1 : sum_full[RAD_W-1:0];
         sum_meta_ff <= sq_meta_ff;
         rt_root_ff[0] <= rt_root_in[0];
         rt_rad_ff[0]  <= sum_rad_ff;
         rt_meta_ff[0] <= sum_meta_ff;
         for (int k = 1; k < NS; k++) begin
            rt_root_ff[k] <= rt_root_in[k];
            rt_rad_ff[k]  <= rt_rad_ff[k-1];
            rt_meta_ff[k] <= rt_meta_ff[k-1];
         end
      end
   end

   assign rsp_empty     = !rt_vld_ff[NS-1];
   assign rsp_magnitude = rt_root_ff[NS-1];
   assign rsp_column    = rt_meta_ff[NS-1].column;
   assign rsp_row       = rt_meta_ff[NS-1].row;
   assign rsp_frame_end = rt_meta_ff[NS-1].frame_end;

endmodule
`default_nettype wire

// File: rtl/sobel_gradient_magnitude.sv
// Top level of the 3x3 Sobel gradient magnitude filter.
//
// Pixels enter in raster order on the request queue: req_pixel is taken at a
// clock edge with req_push high and req_full low. For every interior pixel a
// result (magnitude, column, row, frame_end) leaves on the response queue; it
// is offered while rsp_empty is low and taken at an edge with rsp_pop high.
// The result for pixel (x,y) is produced by the request carrying (x+1,y+1);
// border pixels give none. frame_end marks the last interior result.
// image_width (index 0) and image_height (index 1) are written through
// csr_we/csr_index/csr_data. The user must write them only while the block is
// idle; the block itself does not enforce this. One request is taken per cycle
// while responses are popped; the rate is set by the single line store port
// pair (one read at intake, one write from the window stage). The root pipeline
// stalls as a whole while a response waits, and a four-entry queue between
// the window stage and the root pipeline absorbs requests in flight; req_full
// rises once that queue is nearly full.
// Reset is synchronous: it restarts the raster at column 0, row 0, restores
// 640 x 480 and empties the pipeline. The line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [sgm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sgm_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [sgm_pkg::PIX_W-1:0]      req_pixel,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output logic [sgm_pkg::PIX_W-1:0]           rsp_magnitude,
   output logic [sgm_pkg::COL_W-1:0]           rsp_column,
   output logic [sgm_pkg::ROW_W-1:0]           rsp_row,
   output logic                                rsp_frame_end
);
   import sgm_pkg::*;

   logic          fifo_push;
   logic          fifo_pop;
   item_type      push_item;
   item_type      head_item;
   fifo_stat_type fifo_stat;

   sgm_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .q_stat    (fifo_stat),
      .q_push    (fifo_push),
      .q_item    (push_item)
   );

   sgm_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_item (push_item),
      .pop       (fifo_pop),
      .head_item (head_item),
      .stat      (fifo_stat)
   );

   sgm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (fifo_stat),
      .q_item        (head_item),
      .q_pop         (fifo_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_magnitude (rsp_magnitude),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_frame_end (rsp_frame_end)
   );

   // The intake throttle must keep the window stage from pushing into a full queue.
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_stat.full)
      else $error("window stage pushed into a full queue");

   a_fifo_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_stat.empty)
      else $error("root pipeline popped an empty queue");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response offered right after reset");

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the Sobel gradient magnitude filter.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import sgm_pkg::*;

   localparam int LINE_MAX = MAX_WIDTH_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             frame_end;
   } gradient_type;

   typedef enum int {STYLE_RANDOM, STYLE_EXTREME, STYLE_SMOOTH} pixel_style_type;
   typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_RUNS} pop_mode_type;

   class gradient_scoreboard;
      logic [PIX_W-1:0] line_buf [2*LINE_MAX];
      logic [PIX_W-1:0] window [6];
      int unsigned col_pos;
      int unsigned row_pos;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      gradient_type expected_gradients [$];
      int errors;

      function new();
         foreach (line_buf[i]) line_buf[i] = '0;
         foreach (window[i]) window[i] = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         errors = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg < MIN_DIM) return MIN_DIM;
         if (width_reg > LINE_MAX) return LINE_MAX;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg < MIN_DIM) return MIN_DIM;
         return height_reg;
      endfunction

      function void write_reg(csr_reg_type idx, logic [CFG_W-1:0] val);
         case (idx)
            REG_IMAGE_WIDTH: width_reg = val;
            REG_IMAGE_HEIGHT: height_reg = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_gradients.size();
      endfunction

      // True when the next pixel opens a frame, taking a shrunk geometry into account.
      function bit frame_start();
         int unsigned c, r;
         c = col_pos;
         r = row_pos;
         if (c >= eff_width()) begin
            c = 0;
            r++;
         end
         if (r >= eff_height()) r = 0;
         return (c == 0 && r == 0);
      endfunction

      function logic [PIX_W-1:0] root_sat(int unsigned s);
         int unsigned r, c;
         r = 0;
         if (s >= 65536) return '1;
         for (int b = 7; b >= 0; b--) begin
            c = r | (1 << b);
            if (c * c <= s) r = c;
         end
         return r[PIX_W-1:0];
      endfunction

      function void add_pixel(logic [PIX_W-1:0] pix);
         int unsigned w, h, x, y;
         int lt, lm, lb, ct, cb, rt, rm, rb, gx, gy;
         logic [PIX_W-1:0] top, mid;
         gradient_type res;
         w = eff_width();
         h = eff_height();
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         x = col_pos;
         y = row_pos;
         top = line_buf[LINE_MAX + x];
         mid = line_buf[x];
         line_buf[LINE_MAX + x] = mid;
         line_buf[x] = pix;
         if (x >= 2 && y >= 2) begin
            lt = int'(window[0]);
            lm = int'(window[1]);
            lb = int'(window[2]);
            ct = int'(window[3]);
            cb = int'(window[5]);
            rt = int'(top);
            rm = int'(mid);
            rb = int'(pix);
            gx = (rt + 2 * rm + rb) - (lt + 2 * lm + lb);
            gy = (lb + 2 * cb + rb) - (lt + 2 * ct + rt);
            res.magnitude = root_sat(gx * gx + gy * gy);
            res.column = COL_W'(x - 1);
            res.row = ROW_W'(y - 1);
            res.frame_end = (x == w - 1 && y == h - 1);
            expected_gradients.push_back(res);
         end
         window[0] = window[3];
         window[1] = window[4];
         window[2] = window[5];
         window[3] = top;
         window[4] = mid;
         window[5] = pix;
         col_pos = x + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void check_result(gradient_type got);
         gradient_type want;
         if (expected_gradients.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("Unexpected result: magnitude %0d column %0d row %0d frame_end %0b",
                        got.magnitude, got.column, got.row, got.frame_end);
            return;
         end
         want = expected_gradients.pop_front();
         if (got.magnitude !== want.magnitude || got.column !== want.column ||
             got.row !== want.row || got.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("Mismatch: expected magnitude %0d column %0d row %0d frame_end %0b, %s",
                        want.magnitude, want.column, want.row, want.frame_end,
                        $sformatf("got magnitude %0d column %0d row %0d frame_end %0b",
                                  got.magnitude, got.column, got.row, got.frame_end));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_push;
   logic                  req_full;
   logic [PIX_W-1:0]      req_pixel;
   logic                  rsp_pop;
   logic                  rsp_empty;
   logic [PIX_W-1:0]      rsp_magnitude;
   logic [COL_W-1:0]      rsp_column;
   logic [ROW_W-1:0]      rsp_row;
   logic                  rsp_frame_end;

   gradient_scoreboard sb = new();

   int              burst_left = 0;
   bit              gaps_on = 1'b1;
   int              sent_count = 0;
   pixel_style_type pixel_style = STYLE_RANDOM;
   logic [PIX_W-1:0] last_pixel = '0;

   pop_mode_type pop_mode = POP_ALWAYS;
   int           mode_left = 0;
   int           run_left = 0;
   bit           pop_level = 1'b0;

   sobel_gradient_magnitude DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_push(req_push),
      .req_full(req_full),
      .req_pixel(req_pixel),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_magnitude(rsp_magnitude),
      .rsp_column(rsp_column),
      .rsp_row(rsp_row),
      .rsp_frame_end(rsp_frame_end)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Result checking and the receiver's stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result('{rsp_magnitude, rsp_column, rsp_row, rsp_frame_end});
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            pop_mode = pop_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (pop_mode)
            POP_ALWAYS: begin
               rsp_pop <= 1'b1;
            end
            POP_COIN: begin
               rsp_pop <= 1'($urandom_range(0, 1));
            end
            POP_SPARSE: begin
               rsp_pop <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               if (run_left == 0) begin
                  pop_level = !pop_level;
                  run_left = pop_level ? $urandom_range(1, 20) : $urandom_range(1, 40);
               end
               run_left--;
               rsp_pop <= pop_level;
            end
         endcase
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      wait (reset === 1'b0);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [PIX_W-1:0] next_pixel();
      case (pixel_style)
         STYLE_EXTREME: last_pixel = $urandom_range(0, 1) ? '1 : '0;
         STYLE_SMOOTH: last_pixel = last_pixel + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
         default: last_pixel = PIX_W'($urandom);
      endcase
      return last_pixel;
   endfunction

   // The caller returns in the step of acceptance with req_push still high; the
   // next call or a drain lowers or reuses it in that same step.
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_push <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full);
      sb.add_pixel(pix);
      sent_count++;
   endtask

   task automatic push_pixels(input int count);
      repeat (count) send_pixel(next_pixel());
   endtask

   task automatic finish_frame();
      while (!sb.frame_start()) send_pixel(next_pixel());
   endtask

   // Stops the sender, waits for every expected result, then lets requests that
   // make no result leave the pipeline.
   task automatic drain_and_hold();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      drain_and_hold();
      csr_we <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data <= w;
      @(posedge clock);
      sb.write_reg(REG_IMAGE_WIDTH, w);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      sb.write_reg(REG_IMAGE_HEIGHT, h);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         0: return CFG_W'($urandom_range(0, 2));
         1: return CFG_W'($urandom_range(17, 48));
         default: return CFG_W'($urandom_range(3, 16));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_height();
      case ($urandom_range(0, 9))
         0: return CFG_W'($urandom_range(0, 2));
         1: return CFG_W'($urandom_range(9, 12));
         default: return CFG_W'($urandom_range(3, 8));
      endcase
   endfunction

   initial begin
      logic [CFG_W-1:0] new_w;
      logic [CFG_W-1:0] new_h;
      int random_goal;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_IMAGE_WIDTH;
      csr_data = '0;
      req_push = 1'b0;
      req_pixel = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame: a vertical step that saturates, a flat frame, a mild ramp.
      reconfigure(12'd3, 12'd3);
      for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
      for (int i = 0; i < 9; i++) send_pixel(8'hFF);
      reconfigure(12'd1, 12'd0);
      for (int i = 0; i < 9; i++) send_pixel(PIX_W'(i * 9));

      // A wider frame of three full rows.
      pixel_style = STYLE_RANDOM;
      reconfigure(12'd100, 12'd3);
      push_pixels(300);

      // Tallest height, then cut below the current row so the frame restarts.
      reconfigure(12'd2, 12'hFFF);
      push_pixels(15);
      reconfigure(12'd2, 12'd2);
      push_pixels(9);

      // Width lowered mid-row: first past the current column, then ahead of it.
      reconfigure(12'd10, 12'd6);
      push_pixels(37);
      reconfigure(12'd5, 12'd6);
      push_pixels(7);
      reconfigure(12'd4, 12'd6);
      finish_frame();

      random_goal = sent_count + RANDOM_REQUESTS;
      while (sent_count < random_goal) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         pixel_style = pixel_style_type'($urandom_range(0, 2));
         // Mid-frame the width may only shrink, so no unwritten line entry is read.
         if (sb.frame_start())
            new_w = pick_width();
         else
            new_w = CFG_W'($urandom_range(0, sb.eff_width()));
         new_h = pick_height();
         reconfigure(new_w, new_h);
         finish_frame();
         repeat ($urandom_range(1, 3)) begin
            send_pixel(next_pixel());
            finish_frame();
            if ($urandom_range(0, 7) == 0) drain_and_hold();
         end
         if ($urandom_range(0, 2) == 0)
            push_pixels($urandom_range(1, sb.eff_width() * sb.eff_height() - 1));
      end

      drain_and_hold();
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
rtl/sgm_pkg.sv
rtl/sgm_ram.sv
rtl/sgm_fifo.sv
rtl/sgm_front.sv
rtl/sgm_back.sv
rtl/sobel_gradient_magnitude.sv
test/testbench.sv
